// ----- hw/rtl/slr_pkg.sv -----
package slr_pkg;

   localparam int NUM_WEIGHTS = 1024;
   localparam int W_AW = $clog2(NUM_WEIGHTS);
   localparam int MAX_FEAT = 64;
   localparam int BUF_AW = $clog2(MAX_FEAT);
   localparam int CNT_W = $clog2(MAX_FEAT + 1);
   localparam int SIG_SIZE = 256;
   localparam int SIG_AW = $clog2(SIG_SIZE);
   localparam int ACC_W = 56;
   localparam int CSR_IDX_W = 2;

   localparam logic [2:0] ACT_PREDICT = 3'd0;
   localparam logic [2:0] ACT_TRAIN = 3'd1;
   localparam logic [2:0] ACT_WRITE = 3'd2;
   localparam logic [2:0] ACT_READ = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FEATURES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 2'd1;

   localparam logic [15:0] RATE_RESET = 16'd3277;

   typedef logic [15:0] sig_table_type [SIG_SIZE];

   localparam longint unsigned Q30_ONE = 64'd1 << 30;

   // Unsigned quotient by shift and subtract, used only while building the table.
   function automatic longint unsigned udiv_u64(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 64'd0;
      r = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-f) in Q30 for 0 <= f <= 1.0, truncated Taylor series.
   function automatic longint unsigned exp_neg_q30(longint unsigned f);
      longint sum;
      longint unsigned term;
      sum = longint'(Q30_ONE);
      term = Q30_ONE;
      for (int n = 1; n <= 20; n++) begin
         term = udiv_u64((term * f) >> 30, 64'(n));
         if ((n & 1) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return (sum < 0) ? 64'd0 : longint'(sum);
   endfunction

   // Sigmoid at the midpoint of each table cell, rounded to Q0.16.
   function automatic logic [15:0] sig_entry(int idx);
      longint num;
      longint unsigned m, tq, whole, e, e1, d, p;
      bit neg;
      num = 2 * longint'(idx) + 1 - longint'(SIG_SIZE);
      neg = num < 0;
      m = neg ? -num : num;
      tq = (m << 33) >> SIG_AW;
      whole = tq >> 30;
      e = exp_neg_q30(tq & (Q30_ONE - 1));
      e1 = exp_neg_q30(Q30_ONE);
      for (int k = 0; k < 16; k++) begin
         if (longint'(k) < whole) e = (e * e1) >> 30;
      end
      d = Q30_ONE + e;
      if (neg) p = udiv_u64((e << 16) + (d >> 1), d);
      else p = udiv_u64((Q30_ONE << 16) + (d >> 1), d);
      return (p > 65535) ? 16'hFFFF : p[15:0];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      for (int i = 0; i < SIG_SIZE; i++) t[i] = sig_entry(i);
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// ----- hw/rtl/slr_req_if.sv -----
interface slr_req_if;
   logic valid;
   logic ready;
   logic [2:0] action;
   logic [15:0] feature_id;
   logic signed [15:0] feature_value;
   logic signed [31:0] weight_value;
   logic sample_class;
   logic last_feature;

   modport source (output valid, action, feature_id, feature_value, weight_value,
                   sample_class, last_feature, input ready);
   modport sink (input valid, action, feature_id, feature_value, weight_value,
                 sample_class, last_feature, output ready);
endinterface

// ----- hw/rtl/slr_rsp_if.sv -----
interface slr_rsp_if;
   logic valid;
   logic ready;
   logic kind;
   logic predicted_class;
   logic [15:0] probability;
   logic class_matches;
   logic signed [31:0] weight_data;
   logic overflow;

   modport source (output valid, kind, predicted_class, probability, class_matches,
                   weight_data, overflow, input ready);
   modport sink (input valid, kind, predicted_class, probability, class_matches,
                 weight_data, overflow, output ready);
endinterface

// ----- hw/rtl/slr_ram.sv -----
module slr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hw/rtl/sparse_logistic_regression_sgd.sv -----
// Feature request: walks S_FRD, S_FMUL and S_FACC when it reaches the weight memory; an
// ignored one is taken in S_IDLE. A last feature adds the S_SIG sigmoid step; training
// then runs S_TSCL once per sample and S_TBRD, S_TWRD, S_TMUL, S_TUPD per buffered
// feature, paced by the single read port of the weight memory. Weight read: S_RISS,
// S_ROUT; weight write: S_WR; clear of all weights: S_CLR. Reset is synchronous; after
// reset the weight memory is cleared one entry a cycle and no request is accepted meanwhile.
module sparse_logistic_regression_sgd
   import slr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   slr_req_if.sink              req_chan,
   slr_rsp_if.source            rsp_chan,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLR   = 4'd1;
   localparam logic [3:0] S_WR    = 4'd2;
   localparam logic [3:0] S_RISS  = 4'd3;
   localparam logic [3:0] S_ROUT  = 4'd4;
   localparam logic [3:0] S_FRD   = 4'd5;
   localparam logic [3:0] S_FMUL  = 4'd6;
   localparam logic [3:0] S_FACC  = 4'd7;
   localparam logic [3:0] S_SIG   = 4'd8;
   localparam logic [3:0] S_TSCL  = 4'd9;
   localparam logic [3:0] S_TBRD  = 4'd10;
   localparam logic [3:0] S_TWRD  = 4'd11;
   localparam logic [3:0] S_TMUL  = 4'd12;
   localparam logic [3:0] S_TUPD  = 4'd13;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   logic [3:0] state_ff, state_in;
   logic [W_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [2:0] action_ff, action_in;
   logic [15:0] id_ff, id_in;
   logic signed [15:0] val_ff, val_in;
   logic signed [31:0] wval_ff, wval_in;
   logic label_ff, label_in;
   logic last_ff, last_in;
   logic [10:0] nf_ff, nf_in;
   logic [15:0] rate_ff, rate_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic ovf_ff, ovf_in;
   logic signed [51:0] prod_ff, prod_in;
   logic signed [33:0] scale_ff, scale_in;
   logic [15:0] p_ff, p_in;
   logic [W_AW-1:0] fid_ff, fid_in;
   logic signed [15:0] bval_ff, bval_in;
   logic signed [31:0] w_ff, w_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic rsp_cls_ff, rsp_cls_in;
   logic [15:0] rsp_prob_ff, rsp_prob_in;
   logic rsp_match_ff, rsp_match_in;
   logic signed [31:0] rsp_wdata_ff, rsp_wdata_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   // Weight memory and sample buffer ports.
   logic w_wr_en;
   logic [W_AW-1:0] w_wr_addr, w_rd_addr;
   logic [31:0] w_wr_data, w_rd_data;
   logic b_wr_en;
   logic [W_AW+15:0] b_wr_data, b_rd_data;

   slr_ram #(.WIDTH(32), .DEPTH(NUM_WEIGHTS)) u_weights (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wr_data),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   slr_ram #(.WIDTH(W_AW + 16), .DEPTH(MAX_FEAT)) u_sample_buf (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (count_ff[BUF_AW-1:0]),
      .wr_data (b_wr_data),
      .rd_addr (k_ff[BUF_AW-1:0]),
      .rd_data (b_rd_data)
   );

   // The one shared multiplier: weight times value for the dot product, rate times
   // error once per training sample, and that scale times value per update.
   logic signed [34:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [51:0] mul_p;

   always_comb begin
      unique case (state_ff)
         S_TSCL: begin
            mul_a = 35'(signed'({label_ff, p_ff}));
            mul_b = signed'({1'b0, rate_ff});
         end
         S_TMUL: begin
            mul_a = 35'(scale_ff);
            mul_b = 17'(bval_ff);
         end
         default: begin
            mul_a = 35'(signed'(w_rd_data));
            mul_b = 17'(val_ff);
         end
      endcase
   end

   assign mul_p = 52'(mul_a * mul_b);

   // Saturating dot product accumulation.
   logic signed [ACC_W:0] acc_sum;
   logic signed [ACC_W-1:0] acc_sat;
   assign acc_sum = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(prod_ff);
   always_comb begin
      priority if (acc_sum > (ACC_W+1)'(ACC_MAX)) acc_sat = ACC_MAX;
      else if (acc_sum < (ACC_W+1)'(ACC_MIN)) acc_sat = ACC_MIN;
      else acc_sat = acc_sum[ACC_W-1:0];
   end

   // Sigmoid table index: the table spans [-8, 8) of the Q28.28 dot product, clamped at both ends.
   logic acc_hi, acc_lo;
   logic [31:0] acc_off;
   logic [SIG_AW-1:0] sig_idx;
   logic [15:0] sig_p;
   logic sig_cls;
   assign acc_hi = !acc_ff[ACC_W-1] && (|acc_ff[ACC_W-2:31]);
   assign acc_lo = acc_ff[ACC_W-1] && !(&acc_ff[ACC_W-2:31]);
   assign acc_off = acc_ff[31:0] ^ 32'h8000_0000;
   always_comb begin
      priority if (acc_hi) sig_idx = '1;
      else if (acc_lo) sig_idx = '0;
      else sig_idx = acc_off[31 -: SIG_AW];
   end
   assign sig_p = SIG_TABLE[sig_idx];
   assign sig_cls = sig_p > 16'd32768;

   // Weight update: round the Q4.44 step to Q16.16 half away from zero, then saturate.
   logic step_neg;
   logic [51:0] step_mag;
   logic [23:0] step_rnd;
   logic signed [33:0] w_diff;
   logic signed [31:0] w_new;
   assign step_neg = prod_ff[51];
   assign step_mag = step_neg ? 52'(-prod_ff) : 52'(prod_ff);
   assign step_rnd = 24'((step_mag + 52'(1 << 27)) >> 28);
   assign w_diff = step_neg ? 34'(w_ff) + 34'(step_rnd) : 34'(w_ff) - 34'(step_rnd);
   always_comb begin
      priority if (w_diff > 34'sh07FFF_FFFF) w_new = 32'sh7FFF_FFFF;
      else if (w_diff < -34'sh08000_0000) w_new = 32'sh8000_0000;
      else w_new = w_diff[31:0];
   end

   logic req_fire, out_busy, id_in_mem, req_id_ok, sample_done;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_busy = rsp_valid_ff && !rsp_chan.ready;
   assign id_in_mem = id_ff[15:W_AW] == '0;
   assign req_id_ok = (req_chan.feature_id[15:W_AW] == '0)
                      && (req_chan.feature_id < 16'(nf_ff));
   assign sample_done = (k_ff + 1'b1) == count_ff;

   assign req_chan.ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      action_in = action_ff;
      id_in = id_ff;
      val_in = val_ff;
      wval_in = wval_ff;
      label_in = label_ff;
      last_in = last_ff;
      nf_in = nf_ff;
      rate_in = rate_ff;
      count_in = count_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      prod_in = prod_ff;
      scale_in = scale_ff;
      p_in = p_ff;
      fid_in = fid_ff;
      bval_in = bval_ff;
      w_in = w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_cls_in = rsp_cls_ff;
      rsp_prob_in = rsp_prob_ff;
      rsp_match_in = rsp_match_ff;
      rsp_wdata_in = rsp_wdata_ff;
      rsp_ovf_in = rsp_ovf_ff;
      w_wr_en = 1'b0;
      w_wr_addr = fid_ff;
      w_wr_data = w_new;
      w_rd_addr = id_ff[W_AW-1:0];
      b_wr_en = 1'b0;
      b_wr_data = {id_ff[W_AW-1:0], val_ff};

      if (csr_wen) begin
         if (csr_index == CSR_NUM_FEATURES) nf_in = csr_wdata[10:0];
         else if (csr_index == CSR_LEARNING_RATE) rate_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               action_in = req_chan.action;
               id_in = req_chan.feature_id;
               val_in = req_chan.feature_value;
               wval_in = req_chan.weight_value;
               label_in = req_chan.sample_class;
               last_in = req_chan.last_feature;
               priority if (req_chan.action == ACT_WRITE) state_in = S_WR;
               else if (req_chan.action == ACT_READ) state_in = S_RISS;
               else if (req_chan.action == ACT_CLEAR) begin
                  clr_cnt_in = '0;
                  state_in = S_CLR;
               end else if (req_chan.action == ACT_PREDICT
                            || req_chan.action == ACT_TRAIN) begin
                  if (req_id_ok && count_ff < CNT_W'(MAX_FEAT)) state_in = S_FRD;
                  else begin
                     // Past a full buffer the feature is dropped and flagged; an invalid id is dropped unflagged.
                     if (req_id_ok) ovf_in = 1'b1;
                     if (req_chan.last_feature) state_in = S_SIG;
                  end
               end
            end
         end
         S_CLR: begin
            w_wr_en = 1'b1;
            w_wr_addr = clr_cnt_ff;
            w_wr_data = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == W_AW'(NUM_WEIGHTS - 1)) state_in = S_IDLE;
         end
         S_WR: begin
            w_wr_en = id_in_mem;
            w_wr_addr = id_ff[W_AW-1:0];
            w_wr_data = wval_ff;
            state_in = S_IDLE;
         end
         S_RISS: state_in = S_ROUT;
         S_ROUT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = 1'b1;
               rsp_cls_in = 1'b0;
               rsp_prob_in = '0;
               rsp_match_in = 1'b0;
               rsp_ovf_in = 1'b0;
               rsp_wdata_in = id_in_mem ? signed'(w_rd_data) : '0;
               state_in = S_IDLE;
            end
         end
         S_FRD: state_in = S_FMUL;
         S_FMUL: begin
            prod_in = mul_p;
            state_in = S_FACC;
         end
         S_FACC: begin
            acc_in = acc_sat;
            b_wr_en = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = last_ff ? S_SIG : S_IDLE;
         end
         S_SIG: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = 1'b0;
               rsp_cls_in = sig_cls;
               rsp_prob_in = sig_p;
               rsp_match_in = sig_cls == label_ff;
               rsp_ovf_in = ovf_ff;
               rsp_wdata_in = '0;
               p_in = sig_p;
               k_in = '0;
               if (action_ff == ACT_TRAIN && count_ff != '0) state_in = S_TSCL;
               else begin
                  count_in = '0;
                  acc_in = '0;
                  ovf_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         S_TSCL: begin
            scale_in = mul_p[33:0];
            state_in = S_TBRD;
         end
         S_TBRD: state_in = S_TWRD;
         S_TWRD: begin
            fid_in = b_rd_data[W_AW+15:16];
            bval_in = signed'(b_rd_data[15:0]);
            w_rd_addr = b_rd_data[W_AW+15:16];
            state_in = S_TMUL;
         end
         S_TMUL: begin
            w_in = signed'(w_rd_data);
            prod_in = mul_p;
            state_in = S_TUPD;
         end
         S_TUPD: begin
            w_wr_en = 1'b1;
            k_in = k_ff + 1'b1;
            if (sample_done) begin
               count_in = '0;
               acc_in = '0;
               ovf_in = 1'b0;
               state_in = S_IDLE;
            end else state_in = S_TBRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_cnt_ff <= '0;
         nf_ff <= '0;
         rate_ff <= RATE_RESET;
         count_ff <= '0;
         acc_ff <= '0;
         ovf_ff <= 1'b0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         nf_ff <= nf_in;
         rate_ff <= rate_in;
         count_ff <= count_in;
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      id_ff <= id_in;
      val_ff <= val_in;
      wval_ff <= wval_in;
      label_ff <= label_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      scale_ff <= scale_in;
      p_ff <= p_in;
      fid_ff <= fid_in;
      bval_ff <= bval_in;
      w_ff <= w_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_cls_ff <= rsp_cls_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_match_ff <= rsp_match_in;
      rsp_wdata_ff <= rsp_wdata_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind = rsp_kind_ff;
   assign rsp_chan.predicted_class = rsp_cls_ff;
   assign rsp_chan.probability = rsp_prob_ff;
   assign rsp_chan.class_matches = rsp_match_ff;
   assign rsp_chan.weight_data = rsp_wdata_ff;
   assign rsp_chan.overflow = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FEAT))
      else $error("buffered count exceeds buffer depth");

   a_sig_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIG && !out_busy) |=> rsp_valid_ff && !rsp_kind_ff)
      else $error("sigmoid step did not present a prediction");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TBRD) |-> (k_ff < count_ff))
      else $error("training walk past buffered features");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |=> (state_ff == S_CLR || state_ff == S_IDLE))
      else $error("clear pass left to a working state");
`endif

endmodule

// ----- tb/sparse_logistic_regression_sgd_tb.sv -----
`timescale 1ns / 1ps

module sparse_logistic_regression_sgd_tb;
   import slr_pkg::*;

   // One request as the testbench sees it before it goes on the wire.
   typedef struct {
      logic [2:0]         action;
      logic [15:0]        feature_id;
      logic signed [15:0] feature_value;
      logic signed [31:0] weight_value;
      logic               sample_class;
      logic               last_feature;
   } slr_request_type;

   // One response as it is expected on the result channel.
   typedef struct {
      logic               kind;
      logic               predicted_class;
      logic [15:0]        probability;
      logic               class_matches;
      logic signed [31:0] weight_data;
      logic               overflow;
   } slr_response_type;

   localparam int CYCLE_LIMIT = 2000000;
   // Clearing the weights and a long training walk give no response; this settle
   // time covers any such work still in flight.
   localparam int SETTLE_CYCLES = 1200;

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0] csr_wdata;

   slr_req_if req ();
   slr_rsp_if rsp ();

   sparse_logistic_regression_sgd uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req.sink),
      .rsp_chan  (rsp.source),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Requests waiting to be driven and responses waiting to be seen.
   slr_request_type  pending_requests[$];
   slr_response_type expected_responses[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Predictor state: its own copy of the weights, sample buffer and registers.
   logic signed [31:0] model_weights [NUM_WEIGHTS];
   logic [9:0]         model_ids [MAX_FEAT];
   logic signed [15:0] model_values [MAX_FEAT];
   int unsigned        model_count;
   longint             model_dot;
   logic               model_overflow;
   logic [10:0]        model_num_features;
   logic [15:0]        model_rate;
   logic [15:0]        sigmoid_lut [SIG_SIZE];

   // Driver and receiver pacing.
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stall_mode;
   int unsigned stall_timer;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // exp(-f) with f in Q30, 0 <= f <= 1, by a 21-term Taylor series.
   function automatic longint unsigned exp_neg_fixed(longint unsigned f);
      longint acc;
      longint unsigned term;
      acc = longint'(64'd1 << 30);
      term = 64'd1 << 30;
      for (int n = 1; n <= 20; n++) begin
         term = ((term * f) >> 30) / longint'(n);
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      return (acc < 0) ? 64'd0 : longint'(acc);
   endfunction

   // Sigmoid at the midpoint of table cell idx, rounded to Q0.16.
   function automatic logic [15:0] sigmoid_cell(int idx);
      longint num;
      longint unsigned mag, t, whole, e, e1, d, p;
      bit neg;
      num = 2 * longint'(idx) + 1 - longint'(SIG_SIZE);
      neg = num < 0;
      mag = neg ? -num : num;
      t = (mag << 33) / SIG_SIZE;
      whole = t >> 30;
      e = exp_neg_fixed(t & ((64'd1 << 30) - 1));
      e1 = exp_neg_fixed(64'd1 << 30);
      for (longint unsigned k = 0; k < whole && k < 16; k++) e = (e * e1) >> 30;
      d = (64'd1 << 30) + e;
      if (neg) p = ((e << 16) + d / 2) / d;
      else p = (((64'd1 << 30) << 16) + d / 2) / d;
      return (p > 65535) ? 16'hFFFF : p[15:0];
   endfunction

   initial begin
      for (int i = 0; i < SIG_SIZE; i++) sigmoid_lut[i] = sigmoid_cell(i);
      for (int i = 0; i < NUM_WEIGHTS; i++) model_weights[i] = '0;
      model_count = 0;
      model_dot = 0;
      model_overflow = 1'b0;
      model_num_features = 11'd0;
      model_rate = RATE_RESET;
   end

   // Works out what one accepted request does and queues its response, if any.
   function automatic void predict_request(slr_request_type r);
      slr_response_type res;
      longint acc, err, prod, delta;
      longint unsigned mag, idx;
      logic [15:0] p;
      int unsigned fid;
      res = '{default: '0};
      case (r.action)
         ACT_WRITE: begin
            if (r.feature_id < NUM_WEIGHTS) model_weights[r.feature_id] = r.weight_value;
         end
         ACT_READ: begin
            res.kind = 1'b1;
            if (r.feature_id < NUM_WEIGHTS) res.weight_data = model_weights[r.feature_id];
            expected_responses.insert(expected_responses.size(), res);
         end
         ACT_CLEAR: begin
            for (int i = 0; i < NUM_WEIGHTS; i++) model_weights[i] = '0;
         end
         ACT_PREDICT, ACT_TRAIN: begin
            // A feature counts only below num_features and inside the memory.
            if (r.feature_id < model_num_features && r.feature_id < NUM_WEIGHTS) begin
               if (model_count < MAX_FEAT) begin
                  acc = model_dot + longint'(model_weights[r.feature_id]) *
                        longint'(r.feature_value);
                  if (acc > (64'sd1 <<< 55) - 1) acc = (64'sd1 <<< 55) - 1;
                  if (acc < -(64'sd1 <<< 55)) acc = -(64'sd1 <<< 55);
                  model_dot = acc;
                  model_ids[model_count] = r.feature_id[9:0];
                  model_values[model_count] = r.feature_value;
                  model_count++;
               end else begin
                  model_overflow = 1'b1;
               end
            end
            if (r.last_feature) begin
               // Index the table over [-8, 8) in steps of 1/16.
               if (model_dot >= (64'sd1 <<< 31)) idx = SIG_SIZE - 1;
               else if (model_dot < -(64'sd1 <<< 31)) idx = 0;
               else idx = (unsigned'(model_dot + (64'sd1 <<< 31)) * SIG_SIZE) >> 32;
               if (idx >= SIG_SIZE) idx = SIG_SIZE - 1;
               p = sigmoid_lut[idx];
               res.predicted_class = (p > 16'd32768);
               res.probability = p;
               res.class_matches = (res.predicted_class == r.sample_class);
               res.overflow = model_overflow;
               expected_responses.insert(expected_responses.size(), res);
               if (r.action == ACT_TRAIN) begin
                  err = longint'(p) - (r.sample_class ? 65536 : 0);
                  for (int unsigned k = 0; k < model_count; k++) begin
                     fid = 32'(model_ids[k]);
                     prod = longint'(model_rate) * err * longint'(model_values[k]);
                     mag = (prod < 0) ? -prod : prod;
                     delta = longint'((mag + (64'd1 << 27)) >> 28);
                     if (prod < 0) delta = -delta;
                     acc = longint'(model_weights[fid]) - delta;
                     if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                     if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                     model_weights[fid] = acc[31:0];
                  end
               end
               model_count = 0;
               model_dot = 0;
               model_overflow = 1'b0;
            end
         end
         default: ;  // Unknown actions are dropped by the block.
      endcase
   endfunction

   // Register writes reach the predictor at the same edge that the block takes them.
   always @(posedge clock) begin
      if (!reset && csr_wen) begin
         if (csr_index == CSR_NUM_FEATURES) model_num_features = csr_wdata[10:0];
         else if (csr_index == CSR_LEARNING_RATE) model_rate = csr_wdata;
      end
   end

   // Driver: sends queued requests in bursts of random length with random gaps.
   always @(posedge clock) begin : request_driver
      slr_request_type nxt;
      if (reset) begin
         req.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req.valid && req.ready) begin
            nxt.action = req.action;
            nxt.feature_id = req.feature_id;
            nxt.feature_value = req.feature_value;
            nxt.weight_value = req.weight_value;
            nxt.sample_class = req.sample_class;
            nxt.last_feature = req.last_feature;
            predict_request(nxt);
         end
         if (!req.valid || req.ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req.valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               nxt = pending_requests.pop_front();
               req.action <= nxt.action;
               req.feature_id <= nxt.feature_id;
               req.feature_value <= nxt.feature_value;
               req.weight_value <= nxt.weight_value;
               req.sample_class <= nxt.sample_class;
               req.last_feature <= nxt.last_feature;
               req.valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: the ready pattern switches between always ready, random stalls
   // and a slow one-in-four rate every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_mode <= 0;
         stall_timer <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(16, 128);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= 1'($urandom_range(0, 1));
            default: rsp.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: every response is compared field by field with the oldest expectation.
   always @(posedge clock) begin : response_monitor
      slr_response_type exp_rsp;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected response: kind %0d prob %0d weight %0d",
                        rsp.kind, rsp.probability, rsp.weight_data);
         end else begin
            exp_rsp = expected_responses.pop_front();
            if (rsp.kind !== exp_rsp.kind ||
                rsp.predicted_class !== exp_rsp.predicted_class ||
                rsp.probability !== exp_rsp.probability ||
                rsp.class_matches !== exp_rsp.class_matches ||
                rsp.weight_data !== exp_rsp.weight_data ||
                rsp.overflow !== exp_rsp.overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Response mismatch: expected kind %0d class %0d prob %0d ",
                            "match %0d weight %0d ovf %0d, got %0d %0d %0d %0d %0d %0d"},
                           exp_rsp.kind, exp_rsp.predicted_class, exp_rsp.probability,
                           exp_rsp.class_matches, exp_rsp.weight_data, exp_rsp.overflow,
                           rsp.kind, rsp.predicted_class, rsp.probability,
                           rsp.class_matches, rsp.weight_data, rsp.overflow);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send(input logic [2:0] action, input logic [15:0] id,
                       input logic signed [15:0] value, input logic signed [31:0] weight,
                       input logic label, input logic last);
      slr_request_type r;
      r.action = action;
      r.feature_id = id;
      r.feature_value = value;
      r.weight_value = weight;
      r.sample_class = label;
      r.last_feature = last;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // Waits until every request is out and every response is in, then lets
   // the block finish any work that produces no response.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req.valid || expected_responses.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [15:0] data);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // Random traffic: mostly well-formed samples with random content, mixed with
   // weight writes, reads, the odd clear and some unknown actions.
   task automatic random_traffic(input int unsigned n_items, input int unsigned nf);
      int unsigned sent, r, len, mode;
      logic label;
      logic [15:0] id;
      logic signed [31:0] w;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
            w = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                            : 32'($urandom_range(0, 131071)) - 32'sd65536;
            send(ACT_WRITE, id, 16'($urandom), w, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
            sent++;
         end else if (r < 14) begin
            id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
            send(ACT_READ, id, 16'($urandom), 32'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
            sent++;
         end else if (r == 14) begin
            if ($urandom_range(0, 3) == 0) begin
               send(ACT_CLEAR, 16'($urandom), 16'($urandom), 32'($urandom), 1'b0, 1'b0);
               sent++;
            end
         end else if (r < 17) begin
            send(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom), 32'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            // A sample; now and then longer than the feature buffer.
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            mode = $urandom_range(0, 1);
            label = 1'($urandom_range(0, 1));
            for (int unsigned k = 0; k < len; k++) begin
               if ($urandom_range(0, 6) == 0) id = 16'($urandom);
               else if (nf == 0) id = 16'($urandom_range(0, 1023));
               else id = 16'($urandom_range(0, nf - 1));
               send((k == len - 1) ? 3'(mode) : 3'($urandom_range(0, 1)), id,
                    16'($urandom), 32'($urandom),
                    (k == len - 1) ? label : 1'($urandom_range(0, 1)), k == len - 1);
            end
            sent += len;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = CSR_NUM_FEATURES;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.action = ACT_PREDICT;
      req.feature_id = '0;
      req.feature_value = '0;
      req.weight_value = '0;
      req.sample_class = 1'b0;
      req.last_feature = 1'b0;
      rsp.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // With num_features at zero every feature is ignored, yet the last one
      // still closes the sample.
      wait_idle();
      send(ACT_TRAIN, 16'd0, 16'sd4096, 32'sd0, 1'b1, 1'b1);
      send(ACT_READ, 16'd7, 16'sd0, 32'sd0, 1'b0, 1'b0);
      wait_idle();

      write_csr(CSR_NUM_FEATURES, 16'd1024);
      write_csr(CSR_LEARNING_RATE, 16'd3277);

      // Directed: weight extremes, a write past the memory, reads in and out of
      // range, saturated probabilities, an ignored feature, unknown actions, clear.
      send(ACT_WRITE, 16'd0, 16'sd0, 32'sh7FFFFFFF, 1'b0, 1'b0);
      send(ACT_WRITE, 16'd1, 16'sd0, 32'sh80000000, 1'b0, 1'b0);
      send(ACT_WRITE, 16'd1023, 16'sd0, 32'sh00010000, 1'b0, 1'b0);
      send(ACT_WRITE, 16'd65535, 16'sd0, 32'sh12345678, 1'b0, 1'b0);
      send(ACT_READ, 16'd0, 16'sd0, 32'sd0, 1'b0, 1'b0);
      send(ACT_READ, 16'd1, 16'sd0, 32'sd0, 1'b0, 1'b0);
      send(ACT_READ, 16'd1023, 16'sd0, 32'sd0, 1'b0, 1'b0);
      send(ACT_READ, 16'd65535, 16'sd0, 32'sd0, 1'b0, 1'b0);
      send(ACT_PREDICT, 16'd0, 16'sh7FFF, 32'sd0, 1'b1, 1'b1);
      send(ACT_PREDICT, 16'd1, 16'sh7FFF, 32'sd0, 1'b1, 1'b1);
      send(ACT_TRAIN, 16'd1023, 16'sh8000, 32'sd0, 1'b1, 1'b0);
      send(ACT_READ, 16'd1023, 16'sd0, 32'sd0, 1'b0, 1'b0);
      send(ACT_TRAIN, 16'd5000, 16'sh7FFF, 32'sd0, 1'b1, 1'b1);
      send(ACT_READ, 16'd1023, 16'sd0, 32'sd0, 1'b0, 1'b0);
      send(3'd5, 16'd0, 16'sd0, 32'sd0, 1'b0, 1'b1);
      send(3'd6, 16'd0, 16'sd0, 32'sd0, 1'b0, 1'b1);
      send(3'd7, 16'd0, 16'sd0, 32'sd0, 1'b0, 1'b1);
      send(ACT_CLEAR, 16'd0, 16'sd0, 32'sd0, 1'b0, 1'b0);
      send(ACT_READ, 16'd0, 16'sd0, 32'sd0, 1'b0, 1'b0);
      send(ACT_PREDICT, 16'd0, 16'sd0, 32'sd0, 1'b0, 1'b1);
      wait_idle();

      random_traffic(400, 1024);
      wait_idle();

      write_csr(CSR_NUM_FEATURES, 16'd40);
      write_csr(CSR_LEARNING_RATE, 16'hFFFF);
      random_traffic(400, 40);
      wait_idle();

      // A single weight in use makes buffer overflow common.
      write_csr(CSR_NUM_FEATURES, 16'd1);
      write_csr(CSR_LEARNING_RATE, 16'd0);
      random_traffic(350, 1);
      wait_idle();

      write_csr(CSR_NUM_FEATURES, 16'd1024);
      write_csr(CSR_LEARNING_RATE, 16'($urandom));
      random_traffic(400, 1024);
      wait_idle();

      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sparse_logistic_regression_sgd.f -----
hw/rtl/slr_pkg.sv
hw/rtl/slr_req_if.sv
hw/rtl/slr_rsp_if.sv
hw/rtl/slr_ram.sv
hw/rtl/sparse_logistic_regression_sgd.sv
tb/sparse_logistic_regression_sgd_tb.sv
